### rtl/core/imu_gyro_bias_autocal_defines.svh
// Assertion macros for the gyro bias auto-calibration block
`ifndef IMU_GYRO_BIAS_AUTOCAL_DEFINES_SVH
`define IMU_GYRO_BIAS_AUTOCAL_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define IGBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IGBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/igba_pkg.sv
// Shared types and constants of the gyro bias auto-calibration block
`timescale 1ns / 1ps

package igba_pkg;

  localparam int unsigned AxisMax       = 3;
  localparam int unsigned AxisCountDef  = 3;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic [31:0] FirstDtUs = 32'd1000;
  localparam logic [19:0] UsPerS    = 20'd1000000;

  localparam logic [15:0] AccelAlphaRst     = 16'd66;
  localparam logic [15:0] GyroAlphaRst      = 16'd131;
  localparam logic [31:0] AccelRateLimitRst = 32'd655360;
  localparam logic [31:0] SteadyPeriodRst   = 32'd1000000;
  localparam logic [30:0] GyroThresholdRst  = 31'd65536;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgAccelAlpha     = 8'd0,
    CfgGyroAlpha      = 8'd1,
    CfgAccelRateLimit = 8'd2,
    CfgSteadyPeriod   = 8'd3,
    CfgGyroThreshold  = 8'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] accel_alpha;
    logic [15:0] gyro_alpha;
    logic [31:0] accel_rate_limit;
    logic [31:0] steady_period_us;
    logic [30:0] bias_trip;
  } cfg_t;

  // filter stage -> decision stage
  typedef struct packed {
    logic [AxisMax-1:0][32:0] delta_mag;  // |filtered accel change|
    logic [AxisMax-1:0][31:0] rate_old;   // gyro average before this sample
    logic [63:0]              allowed;    // rate limit * dt
    logic [31:0]              now;
  } mid_t;

endpackage

### rtl/core/igba_filter.sv
// One Q16.16 low-pass filter step with half-up rounding
`timescale 1ns / 1ps

module igba_filter
  import igba_pkg::*;
(
  input  logic signed [31:0] avg_i,
  input  logic signed [15:0] sample_i,
  input  logic        [15:0] alpha_i,
  output logic signed [31:0] avg_o,
  output logic        [32:0] delta_mag_o
);

  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [33:0] step;
  logic        [33:0] step_neg;

  always_comb begin
    diff     = $signed({sample_i[15], sample_i, 16'h0000}) - $signed({avg_i[31], avg_i});
    prod     = diff * $signed({1'b0, alpha_i}) + 50'sd32768;
    step     = prod[49:16];  // floor of prod / 2^16
    step_neg = -step;
    // result stays between avg and sample, so the low word is exact
    avg_o       = avg_i + step[31:0];
    delta_mag_o = step[33] ? step_neg[32:0] : step[32:0];
  end

endmodule

### rtl/core/igba_cfg.sv
// Configuration register file
`timescale 1ns / 1ps

module igba_cfg
  import igba_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_alpha      <= AccelAlphaRst;
      cfg_q.gyro_alpha       <= GyroAlphaRst;
      cfg_q.accel_rate_limit <= AccelRateLimitRst;
      cfg_q.steady_period_us <= SteadyPeriodRst;
      cfg_q.bias_trip        <= GyroThresholdRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAccelAlpha:     cfg_q.accel_alpha      <= cfg_data_i[15:0];
        CfgGyroAlpha:      cfg_q.gyro_alpha       <= cfg_data_i[15:0];
        CfgAccelRateLimit: cfg_q.accel_rate_limit <= cfg_data_i;
        CfgSteadyPeriod:   cfg_q.steady_period_us <= cfg_data_i;
        CfgGyroThreshold:  cfg_q.bias_trip        <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/igba_front.sv
// Filter stage: accel and gyro filters, sample interval, allowed change
`timescale 1ns / 1ps

module igba_front
  import igba_pkg::*;
#(
  parameter int unsigned AxisCount = AxisCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [AxisMax-1:0][15:0] accel_i,
  input  logic [AxisMax-1:0][15:0] rate_i,
  input  logic [31:0]              timestamp_i,
  input  logic                     take_i,
  output logic                     mid_valid_o,
  output mid_t                     mid_o
);

  logic [AxisMax-1:0][31:0] accel_avg_q, accel_avg_d;
  logic [AxisMax-1:0][31:0] rate_avg_q, rate_avg_d;
  logic [AxisMax-1:0][32:0] delta_mag;
  logic [31:0]              last_time_q;
  logic                     have_last_q;
  logic                     mid_valid_q;
  mid_t                     mid_q, mid_d;
  logic [31:0]              dt;
  logic                     in_fire;

  assign in_ready_o  = !mid_valid_q || take_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

  for (genvar g = 0; g < AxisMax; g++) begin : g_axis
    if (g < AxisCount) begin : g_on
      logic signed [31:0] acc_new, rate_new;
      logic        [32:0] rate_delta;

      igba_filter u_acc (
        .avg_i       ($signed(accel_avg_q[g])),
        .sample_i    ($signed(accel_i[g])),
        .alpha_i     (cfg_i.accel_alpha),
        .avg_o       (acc_new),
        .delta_mag_o (delta_mag[g])
      );

      igba_filter u_rate (
        .avg_i       ($signed(rate_avg_q[g])),
        .sample_i    ($signed(rate_i[g])),
        .alpha_i     (cfg_i.gyro_alpha),
        .avg_o       (rate_new),
        .delta_mag_o (rate_delta)
      );

      assign accel_avg_d[g] = acc_new;
      assign rate_avg_d[g]  = rate_new;
    end else begin : g_off
      assign accel_avg_d[g] = '0;
      assign rate_avg_d[g]  = '0;
      assign delta_mag[g]   = '0;
    end
  end

  always_comb begin
    dt                = have_last_q ? (timestamp_i - last_time_q) : FirstDtUs;
    mid_d.delta_mag   = delta_mag;
    mid_d.rate_old    = rate_avg_q;
    mid_d.allowed     = 64'(cfg_i.accel_rate_limit) * 64'(dt);
    mid_d.now         = timestamp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_avg_q <= '0;
      rate_avg_q  <= '0;
      last_time_q <= '0;
      have_last_q <= 1'b0;
      mid_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        mid_valid_q <= in_fire;
      end
      if (in_fire) begin
        accel_avg_q <= accel_avg_d;
        rate_avg_q  <= rate_avg_d;
        last_time_q <= timestamp_i;
        have_last_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mid_q <= mid_d;
    end
  end

endmodule

### rtl/core/igba_back.sv
// Decision stage: steadiness check, moving/steady machine, result register
`timescale 1ns / 1ps

module igba_back
  import igba_pkg::*;
#(
  parameter int unsigned AxisCount = AxisCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     mid_valid_i,
  input  mid_t                     mid_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     is_steady_o,
  output logic                     write_offsets_o,
  output logic [AxisMax-1:0][31:0] correction_o
);

  logic                     steady_q, steady_d;
  logic [31:0]              start_q, start_d;
  logic                     out_valid_q;
  logic                     is_steady_q;
  logic                     write_q, write_d;
  logic [AxisMax-1:0][31:0] corr_q, corr_d;
  logic [AxisMax-1:0]       too_fast;
  logic [AxisMax-1:0]       over_thr;
  logic                     steady_now;
  logic [31:0]              elapsed;
  logic                     load;

  assign take_o          = !out_valid_q || out_ready_i;
  assign load            = take_o && mid_valid_i;
  assign out_valid_o     = out_valid_q;
  assign is_steady_o     = is_steady_q;
  assign write_offsets_o = write_q;
  assign correction_o    = corr_q;

  for (genvar g = 0; g < AxisMax; g++) begin : g_axis
    if (g < AxisCount) begin : g_on
      logic [52:0] scaled;
      logic [31:0] rate_neg, rate_mag;
      assign scaled      = 53'(mid_i.delta_mag[g]) * 53'(UsPerS);
      assign too_fast[g] = 64'(scaled) > mid_i.allowed;
      assign rate_neg    = -mid_i.rate_old[g];
      assign rate_mag    = mid_i.rate_old[g][31] ? rate_neg : mid_i.rate_old[g];
      assign over_thr[g] = rate_mag > {1'b0, cfg_i.bias_trip};
    end else begin : g_off
      assign too_fast[g] = 1'b0;
      assign over_thr[g] = 1'b0;
    end
  end

  always_comb begin
    steady_now = ~|too_fast;
    steady_d   = steady_q;
    start_d    = start_q;
    write_d    = 1'b0;
    corr_d     = '0;
    if (steady_now && !steady_q) begin
      steady_d = 1'b1;
      start_d  = mid_i.now;
    end else if (!steady_now && steady_q) begin
      steady_d = 1'b0;
    end
    elapsed = mid_i.now - start_d;
    if (steady_d && (elapsed > cfg_i.steady_period_us) && (|over_thr)) begin
      write_d  = 1'b1;
      corr_d   = mid_i.rate_old;
      steady_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steady_q    <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        out_valid_q <= mid_valid_i;
      end
      if (load) begin
        steady_q <= steady_d;
        start_q  <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_steady_q <= steady_d;
      write_q     <= write_d;
      corr_q      <= corr_d;
    end
  end

endmodule

### rtl/core/imu_gyro_bias_autocal.sv
// Top level of the stationary gyro bias auto-calibration block
// Path: an accepted sample is registered in the filter stage, then in the result register,
// which offers the result beat until out_ready_i takes it.
// Throughput: one sample per cycle unless out_ready_i stalls; filters and steady logic are combinational.
// Stall: out_ready_i low holds the result register and the filter stage, then in_ready_o drops.
// Reset (rst_ni low, asynchronous): filters, timestamps and steady machine cleared,
// registers back to their defaults, both stages empty.
`timescale 1ns / 1ps

module imu_gyro_bias_autocal
  import igba_pkg::*;
#(
  parameter int unsigned AxisCount = AxisCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       accel_x_i,
  input  logic signed [15:0]       accel_y_i,
  input  logic signed [15:0]       accel_z_i,
  input  logic signed [15:0]       rate_x_i,
  input  logic signed [15:0]       rate_y_i,
  input  logic signed [15:0]       rate_z_i,
  input  logic [31:0]              timestamp_us_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     is_steady_o,
  output logic                     write_offsets_o,
  output logic signed [31:0]       correction_x_o,
  output logic signed [31:0]       correction_y_o,
  output logic signed [31:0]       correction_z_o
);

  cfg_t                     cfg;
  mid_t                     mid;
  logic                     mid_valid;
  logic                     take;
  logic [AxisMax-1:0][15:0] accel;
  logic [AxisMax-1:0][15:0] rate;
  logic [AxisMax-1:0][31:0] corr;

  // lane 0 is x, lane 2 is z
  assign accel = {accel_z_i, accel_y_i, accel_x_i};
  assign rate  = {rate_z_i, rate_y_i, rate_x_i};

  igba_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // stage 1: filters update on the accepted beat, interval and limit product registered
  igba_front #(
    .AxisCount (AxisCount)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_i     (accel),
    .rate_i      (rate),
    .timestamp_i (timestamp_us_i),
    .take_i      (take),
    .mid_valid_o (mid_valid),
    .mid_o       (mid)
  );

  // stage 2: change vs limit, steady machine, correction decision into the result register
  igba_back #(
    .AxisCount (AxisCount)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .mid_valid_i     (mid_valid),
    .mid_i           (mid),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_steady_o     (is_steady_o),
    .write_offsets_o (write_offsets_o),
    .correction_o    (corr)
  );

  assign correction_x_o = $signed(corr[0]);
  assign correction_y_o = $signed(corr[1]);
  assign correction_z_o = $signed(corr[2]);

endmodule

### rtl/core/igba_checker.sv
// Port-level checks for the gyro bias auto-calibration block, bound to the top level
`timescale 1ns / 1ps
`include "imu_gyro_bias_autocal_defines.svh"

module igba_checker
  import igba_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [CfgIndexWidth-1:0] cfg_index_i,
  input logic [CfgDataWidth-1:0]  cfg_data_i,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic signed [15:0]       accel_x_i,
  input logic signed [15:0]       accel_y_i,
  input logic signed [15:0]       accel_z_i,
  input logic signed [15:0]       rate_x_i,
  input logic signed [15:0]       rate_y_i,
  input logic signed [15:0]       rate_z_i,
  input logic [31:0]              timestamp_us_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     is_steady_o,
  input logic                     write_offsets_o,
  input logic signed [31:0]       correction_x_o,
  input logic signed [31:0]       correction_y_o,
  input logic signed [31:0]       correction_z_o
);

  // a correction beat always drops back to moving
  `IGBA_ASSERT_NOW(a_write_leaves_steady, out_valid_o && write_offsets_o, !is_steady_o, "write beat still steady")

  // corrections are zero unless written
  `IGBA_ASSERT_NOW(a_idle_corr_zero, out_valid_o && !write_offsets_o, (correction_x_o == 0) && (correction_y_o == 0) && (correction_z_o == 0), "nonzero correction without write")

  // a write is only triggered by an axis above threshold, so some axis is nonzero
  `IGBA_ASSERT_NOW(a_write_has_corr, out_valid_o && write_offsets_o, (correction_x_o != 0) || (correction_y_o != 0) || (correction_z_o != 0), "write beat with all-zero correction")

  // a stalled result beat stays offered
  `IGBA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")

endmodule

bind imu_gyro_bias_autocal igba_checker u_igba_checker (.*);

### sim/imu_gyro_bias_autocal_tb.sv
// Self-checking bench for the gyro bias auto-calibration block
`timescale 1ns / 1ps

module imu_gyro_bias_autocal_tb;
  import igba_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 12;   // leave plenty of slack past the last result
  localparam int unsigned IdleSettle  = 4;    // quiet cycles before a register beat

  localparam logic signed [15:0] SMin = 16'sh8000;
  localparam logic signed [15:0] SMax = 16'sh7FFF;

  // receiver stall patterns
  typedef enum logic [1:0] {
    SinkOpen,
    SinkRandom,
    SinkSparse
  } sink_mode_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [31:0]        timestamp_us;
  } imu_sample_t;

  // one entry of the stimulus stream: a sample beat or a register write
  typedef struct packed {
    logic                     is_reg_write;
    logic [CfgIndexWidth-1:0] reg_index;
    logic [CfgDataWidth-1:0]  reg_data;
    imu_sample_t              sample;
  } imu_op_t;

  typedef struct packed {
    logic               is_steady;
    logic               write_offsets;
    logic signed [31:0] corr_x;
    logic signed [31:0] corr_y;
    logic signed [31:0] corr_z;
  } calib_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  imu_sample_t              smp_q       = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     is_steady_o;
  logic                     write_offsets_o;
  logic signed [31:0]       correction_x_o;
  logic signed [31:0]       correction_y_o;
  logic signed [31:0]       correction_z_o;

  imu_gyro_bias_autocal uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .accel_x_i       (smp_q.accel_x),
    .accel_y_i       (smp_q.accel_y),
    .accel_z_i       (smp_q.accel_z),
    .rate_x_i        (smp_q.rate_x),
    .rate_y_i        (smp_q.rate_y),
    .rate_z_i        (smp_q.rate_z),
    .timestamp_us_i  (smp_q.timestamp_us),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_steady_o     (is_steady_o),
    .write_offsets_o (write_offsets_o),
    .correction_x_o  (correction_x_o),
    .correction_y_o  (correction_y_o),
    .correction_z_o  (correction_z_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calibration mirror: registers, filters and the moving/steady machine
  // ---------------------------------------------------------------------------
  cfg_t               cal_cfg;
  logic signed [31:0] accel_lp [3];
  logic signed [31:0] rate_lp  [3];
  logic               steady_m;
  logic [31:0]        steady_since_us;
  logic [31:0]        prev_ts_us;
  logic               seen_ts;

  imu_op_t       imu_ops   [$];
  calib_result_t calib_due [$];

  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned samples_sent  = 0;
  int unsigned regs_written  = 0;
  int unsigned settings_seen = 0;
  int unsigned beats_seen    = 0;
  int unsigned steady_seen   = 0;
  int unsigned pulses_seen   = 0;

  // one low-pass step, half-up rounding; always lands between avg and the sample
  function automatic logic signed [31:0] lp_step(logic signed [31:0] avg,
                                                 logic signed [15:0] x,
                                                 logic [15:0] alpha);
    longint gap;
    longint prod;
    gap  = longint'(x) * 64'sd65536 - longint'(avg);
    prod = gap * longint'(alpha) + 64'sd32768;
    return 32'(longint'(avg) + (prod >>> 16));
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic void write_register(logic [CfgIndexWidth-1:0] idx,
                                         logic [CfgDataWidth-1:0] data);
    case (idx)
      CfgAccelAlpha:     cal_cfg.accel_alpha      = data[15:0];
      CfgGyroAlpha:      cal_cfg.gyro_alpha       = data[15:0];
      CfgAccelRateLimit: cal_cfg.accel_rate_limit = data;
      CfgSteadyPeriod:   cal_cfg.steady_period_us = data;
      CfgGyroThreshold:  cal_cfg.bias_trip        = data[30:0];
      default: ;  // unknown index: no effect
    endcase
  endfunction

  function automatic calib_result_t step_calibration(imu_sample_t s);
    logic signed [15:0] acc [3];
    logic signed [15:0] gyr [3];
    logic signed [31:0] prev;
    logic [31:0]        dt;
    logic [31:0]        held_us;
    logic [63:0]        allowed;
    logic               still;
    calib_result_t      r;
    acc = '{s.accel_x, s.accel_y, s.accel_z};
    gyr = '{s.rate_x, s.rate_y, s.rate_z};
    r   = '0;

    // first sample after reset assumes a nominal interval; later ones wrap mod 2^32
    dt         = seen_ts ? s.timestamp_us - prev_ts_us : FirstDtUs;
    prev_ts_us = s.timestamp_us;
    seen_ts    = 1'b1;

    // |change| * 1e6 against limit * dt, no division
    allowed = 64'(cal_cfg.accel_rate_limit) * 64'(dt);
    still   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      prev        = accel_lp[i];
      accel_lp[i] = lp_step(prev, acc[i], cal_cfg.accel_alpha);
      if (magnitude(longint'(accel_lp[i]) - longint'(prev)) * 64'd1000000 > allowed)
        still = 1'b0;
    end

    if (still && !steady_m) begin
      steady_m        = 1'b1;
      steady_since_us = s.timestamp_us;
    end else if (!still && steady_m) begin
      steady_m = 1'b0;
    end

    held_us = s.timestamp_us - steady_since_us;
    if (steady_m && held_us > cal_cfg.steady_period_us) begin
      for (int i = 0; i < 3; i++)
        if (magnitude(longint'(rate_lp[i])) > 64'(cal_cfg.bias_trip))
          r.write_offsets = 1'b1;
      if (r.write_offsets) begin
        r.corr_x = rate_lp[0];
        r.corr_y = rate_lp[1];
        r.corr_z = rate_lp[2];
        steady_m = 1'b0;
      end
    end

    // gyro filter moves only after the correction decision
    for (int i = 0; i < 3; i++)
      rate_lp[i] = lp_step(rate_lp[i], gyr[i], cal_cfg.gyro_alpha);

    r.is_steady = steady_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  logic [31:0]        ts_cursor = '0;
  logic signed [15:0] pose      [3];
  logic signed [15:0] rate_bias [3];

  task automatic push_sample(input logic signed [15:0] ax, ay, az, rx, ry, rz,
                             input logic [31:0] ts);
    imu_op_t op;
    op        = '0;
    op.sample = '{ax, ay, az, rx, ry, rz, ts};
    imu_ops.push_back(op);
  endtask

  task automatic push_register(input logic [CfgIndexWidth-1:0] idx,
                               input logic [CfgDataWidth-1:0] data);
    imu_op_t op;
    op              = '0;
    op.is_reg_write = 1'b1;
    op.reg_index    = idx;
    op.reg_data     = data;
    imu_ops.push_back(op);
  endtask

  // full register set plus one write to an index that does not exist
  task automatic push_settings(input logic [31:0] aa, ga, rl, sp, th);
    push_register(CfgAccelAlpha, aa);
    push_register(CfgGyroAlpha, ga);
    push_register(CfgAccelRateLimit, rl);
    push_register(CfgSteadyPeriod, sp);
    push_register(CfgGyroThreshold, th);
    push_register(CfgIndexWidth'($urandom_range(int'(CfgGyroThreshold) + 1,
                                                (1 << CfgIndexWidth) - 1)),
                  $urandom());
    settings_seen++;
  endtask

  function automatic logic signed [15:0] wobble(logic signed [15:0] c, int j);
    return c + 16'(int'($urandom_range(0, 2 * j)) - j);
  endfunction

  // mostly held poses with a steady gyro bias, now and then a burst of noise
  task automatic push_random_phase(input int n);
    int          made;
    int          jit;
    logic [31:0] step_max;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 2) == 0)
            pose[i] = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 200) - 100);
          rate_bias[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 4000) - 2000);
        end
        jit      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        step_max = ($urandom_range(0, 4) == 0) ? 32'd20000 : 32'd1500;
        repeat ($urandom_range(5, 30)) begin
          ts_cursor = ts_cursor + 32'($urandom_range(0, step_max));
          push_sample(wobble(pose[0], jit), wobble(pose[1], jit), wobble(pose[2], jit),
                      wobble(rate_bias[0], jit), wobble(rate_bias[1], jit),
                      wobble(rate_bias[2], jit), ts_cursor);
          made++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          // sometimes park just below the wrap so the next run crosses it
          ts_cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + 32'($urandom_range(0, 4095))
                                                  : $urandom();
          push_sample(16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 16'($urandom()), 16'($urandom()), ts_cursor);
          made++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sample and register channels, bursts with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned idle_run   = 0;

  always @(posedge clk_i) begin : drive_block
    logic    in_take;
    logic    cfg_take;
    logic    nxt_in_valid;
    logic    nxt_cfg_valid;
    imu_op_t head;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      in_take  = in_valid_i && in_ready_o;
      cfg_take = cfg_valid_i && cfg_ready_o;
      if (in_take) begin
        calib_due.push_back(step_calibration(smp_q));
        samples_sent++;
      end
      if (cfg_take) begin
        write_register(cfg_index_i, cfg_data_i);
        regs_written++;
      end

      nxt_in_valid  = in_valid_i && !in_take;
      nxt_cfg_valid = cfg_valid_i && !cfg_take;

      // register beats wait for the block to run dry
      if (calib_due.size() == 0 && !in_valid_i)
        idle_run++;
      else
        idle_run = 0;
      if (gap_left != 0)
        gap_left--;

      if (!nxt_in_valid && !nxt_cfg_valid && imu_ops.size() != 0) begin
        head = imu_ops[0];
        if (!head.is_reg_write && gap_left == 0) begin
          imu_ops.delete(0);
          smp_q        <= head.sample;
          nxt_in_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else if (head.is_reg_write && idle_run >= IdleSettle && !in_take) begin
          imu_ops.delete(0);
          cfg_index_i   <= head.reg_index;
          cfg_data_i    <= head.reg_data;
          nxt_cfg_valid = 1'b1;
        end
      end

      in_valid_i  <= nxt_in_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result channel with its own stall pattern
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    $display("MISMATCH at result beat %0d: %s", beats_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  sink_mode_e  sink_mode  = SinkOpen;
  int unsigned sink_left  = 0;
  logic [2:0]  sink_tick  = '0;

  always @(posedge clk_i) begin : watch_block
    calib_result_t want;
    logic          nxt_ready;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (calib_due.size() == 0) begin
          note_mismatch($sformatf("unexpected beat steady=%0b write=%0b",
                                  is_steady_o, write_offsets_o));
        end else begin
          want = calib_due.pop_front();
          check_field("is_steady", 32'(is_steady_o), 32'(want.is_steady));
          check_field("write_offsets", 32'(write_offsets_o), 32'(want.write_offsets));
          check_field("correction_x", correction_x_o, want.corr_x);
          check_field("correction_y", correction_y_o, want.corr_y);
          check_field("correction_z", correction_z_o, want.corr_z);
        end
        beats_seen++;
        if (is_steady_o)
          steady_seen++;
        if (write_offsets_o)
          pulses_seen++;
      end

      if (sink_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    sink_mode = SinkOpen;
          2:       sink_mode = SinkRandom;
          default: sink_mode = SinkSparse;
        endcase
        sink_left = $urandom_range(20, 200);
      end else begin
        sink_left--;
      end
      sink_tick = sink_tick + 3'd1;

      case (sink_mode)
        SinkOpen:   nxt_ready = 1'b1;
        SinkRandom: nxt_ready = 1'($urandom_range(0, 1));
        default:    nxt_ready = (sink_tick == 3'd0);
      endcase
      out_ready_i <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, calib_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cal_cfg         = '{AccelAlphaRst, GyroAlphaRst, AccelRateLimitRst,
                        SteadyPeriodRst, GyroThresholdRst};
    accel_lp        = '{default: '0};
    rate_lp         = '{default: '0};
    steady_m        = 1'b0;
    steady_since_us = '0;
    prev_ts_us      = '0;
    seen_ts         = 1'b0;
    pose            = '{default: '0};
    rate_bias       = '{default: '0};

    // reset defaults: first interval, zero interval with and without change,
    // field extremes and a timestamp wrap
    push_sample(0, 0, 0, 0, 0, 0, 32'h0000_0010);
    push_sample(0, 0, 0, 0, 0, 0, 32'h0000_0010);
    push_sample(SMax, SMax, SMax, 0, 0, 0, 32'h0000_0010);
    push_sample(SMin, SMin, SMin, SMin, SMin, SMin, 32'h0000_03F8);
    push_sample(SMax, SMax, SMax, SMax, SMax, SMax, 32'h0000_07E0);
    push_sample(0, 0, 0, 0, 0, 0, 32'hFFFF_FFF0);
    push_sample(0, 0, 0, 0, 0, 0, 32'h0000_0020);

    // fastest filters, widest limit, zero period and threshold: pulses as soon
    // as steadiness has lasted at all, including across the wrap
    push_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0000_0000);
    push_sample(0, 0, 0, 100, -100, 0, 32'hFFFF_FF00);
    push_sample(0, 0, 0, 100, -100, 0, 32'hFFFF_FFF8);
    push_sample(0, 0, 0, SMax, SMin, 1, 32'h0000_0010);
    push_sample(0, 0, 0, SMax, SMin, 1, 32'h0000_0010);
    push_sample(0, 0, 0, SMin, SMax, -1, 32'h0000_0400);
    push_sample(SMax, SMin, SMax, 0, 0, 0, 32'h0000_0800);
    push_sample(SMax, SMin, SMax, 0, 0, 0, 32'h0000_0C00);

    // frozen filters, no rate allowance, longest period, top threshold
    push_settings(32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_sample(SMin, SMax, SMin, SMax, SMax, SMax, 32'h0000_1000);
    push_sample(SMax, SMin, SMax, SMin, SMin, SMin, 32'h0000_1000);
    push_sample(0, 0, 0, 0, 0, 0, 32'h8000_0000);
    ts_cursor = 32'h8000_0000;
    push_random_phase(60);

    // random settings, accel filter biased fast so that steadiness is reachable
    for (int k = 0; k < 7; k++) begin
      push_settings(($urandom_range(0, 3) == 0) ? $urandom()
                      : {16'($urandom()), 16'($urandom_range(30000, 65535))},
                    $urandom(),
                    $urandom(),
                    ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20000),
                    {1'($urandom()), 31'($urandom_range(0, 1 << 24))});
      push_random_phase(90);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (imu_ops.size() != 0 || calib_due.size() != 0 || in_valid_i || cfg_valid_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d samples and %0d register beats over %0d register settings",
             samples_sent, regs_written, settings_seen + 1);
    $display("Checked %0d result beats: %0d steady, %0d offset write pulses",
             beats_seen, steady_seen, pulses_seen);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
